@@ hw/rtl/rlas_pkg.sv @@
// rlas_pkg: shared types, codes and constants for the rate limited approach step block
// no dependencies; used by every other file of the block

package rlas_pkg;

   localparam int unsigned ValueWidth   = 16;
   localparam int unsigned StepWidth    = 15;
   localparam int unsigned ScaleWidth   = 16;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned CsrIdxWidth  = 2;
   localparam int unsigned DivSteps     = 16;
   localparam int unsigned DivCntWidth  = 4;

   typedef logic [ValueWidth-1:0]   value_type;
   typedef logic [StepWidth-1:0]    step_type;
   typedef logic [ScaleWidth-1:0]   scale_type;
   typedef logic [CsrDataWidth-1:0] csr_data_type;
   typedef logic [CsrIdxWidth-1:0]  csr_idx_type;

   // item commands
   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // register indexes
   localparam csr_idx_type REG_DIVISOR    = 2'd0;
   localparam csr_idx_type REG_MAX_STEP   = 2'd1;
   localparam csr_idx_type REG_MIN_STEP   = 2'd2;
   localparam csr_idx_type REG_TIME_SCALE = 2'd3;

   // register reset values
   localparam step_type  DIVISOR_RST    = 15'd1;
   localparam step_type  MAX_STEP_RST   = 15'h7fff;
   localparam step_type  MIN_STEP_RST   = 15'd1;
   localparam scale_type TIME_SCALE_RST = 16'd256;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV,
      ST_APPLY,
      ST_OUT
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // take in the accepted word
      logic scale;     // scale limits, seed divider
      logic div_step;  // one restoring divide step
      logic apply;     // update the current value
      logic out_load;  // move the result into the output register
   } ctrl_type;

endpackage

@@ hw/rtl/rlas_req_if.sv @@
// rlas_req_if: request channel of the rate limited approach step block
// depends on rlas_pkg

interface rlas_req_if;
   logic                valid;
   logic                ready;
   logic                cmd;
   rlas_pkg::value_type target;

   modport source (output valid, output cmd, output target, input ready);
   modport sink   (input valid, input cmd, input target, output ready);
endinterface

@@ hw/rtl/rlas_rsp_if.sv @@
// rlas_rsp_if: result channel of the rate limited approach step block
// depends on rlas_pkg

interface rlas_rsp_if;
   logic                valid;
   logic                ready;
   rlas_pkg::value_type new_value;
   rlas_pkg::value_type diff_before;

   modport source (output valid, output new_value, output diff_before, input ready);
   modport sink   (input valid, input new_value, input diff_before, output ready);
endinterface

@@ hw/rtl/rlas_ctrl.sv @@
// rlas_ctrl: sequencer of the rate limited approach step block
// depends on rlas_pkg; drives the datapath through rlas_pkg::ctrl_type

module rlas_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rlas_pkg::ctrl_type ctrl
);

   rlas_pkg::state_type state_ff, state_in;
   logic [rlas_pkg::DivCntWidth-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlas_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ctrl      = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         rlas_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = rlas_pkg::ST_SCALE;
            end
         end
         rlas_pkg::ST_SCALE: begin
            ctrl.scale = 1'b1;
            cnt_in     = '0;
            state_in   = rlas_pkg::ST_DIV;
         end
         rlas_pkg::ST_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == rlas_pkg::DivCntWidth'(rlas_pkg::DivSteps - 1)) begin
               state_in = rlas_pkg::ST_APPLY;
            end
         end
         rlas_pkg::ST_APPLY: begin
            ctrl.apply = 1'b1;
            state_in   = rlas_pkg::ST_OUT;
         end
         rlas_pkg::ST_OUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.out_load = 1'b1;
               state_in      = rlas_pkg::ST_IDLE;
            end
         end
         default: state_in = rlas_pkg::ST_IDLE;
      endcase
      rsp_valid_in = ctrl.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hw/rtl/rlas_dpath.sv @@
// rlas_dpath: registers, scaling multipliers, divider and step logic
// depends on rlas_pkg; controlled by rlas_ctrl through rlas_pkg::ctrl_type

module rlas_dpath (
   input  logic                   clock,
   input  logic                   reset,
   input  rlas_pkg::ctrl_type     ctrl,
   input  logic                   csr_wr_en,
   input  rlas_pkg::csr_idx_type  csr_index,
   input  rlas_pkg::csr_data_type csr_wdata,
   input  logic                   req_cmd,
   input  rlas_pkg::value_type    req_target,
   output rlas_pkg::value_type    rsp_new_value,
   output rlas_pkg::value_type    rsp_diff_before
);

   rlas_pkg::step_type  divisor_ff, max_step_ff, min_step_ff;
   rlas_pkg::scale_type time_scale_ff;

   rlas_pkg::value_type cur_ff, cur_in;
   rlas_pkg::value_type tgt_ff, diff_ff;
   logic                cmd_ff;
   rlas_pkg::step_type  mx_ff, mn_ff;
   rlas_pkg::value_type rem_ff, quo_ff;
   rlas_pkg::value_type res_val_ff, res_diff_ff;
   rlas_pkg::value_type out_val_ff, out_diff_ff;

   logic [30:0]         prod_mx, prod_mn;
   rlas_pkg::step_type  mx_in, mn_in;
   rlas_pkg::step_type  dv;
   rlas_pkg::value_type diff_mag;
   rlas_pkg::value_type shifted;
   logic                fits;
   logic                neg, big;
   rlas_pkg::step_type  step;
   rlas_pkg::value_type moved, chk;
   logic                snap;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff    <= rlas_pkg::DIVISOR_RST;
         max_step_ff   <= rlas_pkg::MAX_STEP_RST;
         min_step_ff   <= rlas_pkg::MIN_STEP_RST;
         time_scale_ff <= rlas_pkg::TIME_SCALE_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rlas_pkg::REG_DIVISOR:    divisor_ff    <= csr_wdata[14:0];
            rlas_pkg::REG_MAX_STEP:   max_step_ff   <= csr_wdata[14:0];
            rlas_pkg::REG_MIN_STEP:   min_step_ff   <= csr_wdata[14:0];
            rlas_pkg::REG_TIME_SCALE: time_scale_ff <= csr_wdata;
            default:                  ;
         endcase
      end
   end

   // scaled limits, truncated q8.8 product saturated to 15 bits
   always_comb begin
      prod_mx = 31'(max_step_ff) * 31'(time_scale_ff);
      prod_mn = 31'(min_step_ff) * 31'(time_scale_ff);
      mx_in   = (|prod_mx[30:23]) ? 15'h7fff : prod_mx[22:8];
      mn_in   = (|prod_mn[30:23]) ? 15'h7fff : prod_mn[22:8];
      dv      = (divisor_ff == '0) ? 15'd1 : divisor_ff;
      diff_mag = diff_ff[15] ? (16'd0 - diff_ff) : diff_ff;
   end

   // restoring divide step; remainder stays below the divisor so 15 bits suffice
   always_comb begin
      shifted = {rem_ff[14:0], quo_ff[15]};
      fits    = shifted >= {1'b0, dv};
   end

   // step rule
   always_comb begin
      neg   = diff_ff[15];
      big   = quo_ff > {1'b0, mn_ff};
      step  = big ? ((quo_ff > {1'b0, mx_ff}) ? mx_ff : quo_ff[14:0]) : mn_ff;
      moved = neg ? (cur_ff - {1'b0, step}) : (cur_ff + {1'b0, step});
      chk   = neg ? (diff_ff + {1'b0, mn_ff}) : (diff_ff - {1'b0, mn_ff});
      // overshoot of the minimum step lands on the target
      snap  = neg ? !chk[15] : (chk[15] || chk == '0);
      if (cmd_ff == rlas_pkg::CMD_LOAD) begin
         cur_in = tgt_ff;
      end else if (diff_ff == '0) begin
         cur_in = cur_ff;
      end else if (big) begin
         cur_in = moved;
      end else begin
         cur_in = snap ? tgt_ff : moved;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
      end else if (ctrl.apply) begin
         cur_ff <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff  <= req_cmd;
         tgt_ff  <= req_target;
         diff_ff <= req_target - cur_ff;
      end
      if (ctrl.scale) begin
         mx_ff  <= mx_in;
         mn_ff  <= mn_in;
         rem_ff <= '0;
         quo_ff <= diff_mag;
      end
      if (ctrl.div_step) begin
         rem_ff <= fits ? (shifted - {1'b0, dv}) : shifted;
         quo_ff <= {quo_ff[14:0], fits};
      end
      if (ctrl.apply) begin
         res_val_ff  <= cur_in;
         res_diff_ff <= diff_ff;
      end
      if (ctrl.out_load) begin
         out_val_ff  <= res_val_ff;
         out_diff_ff <= res_diff_ff;
      end
   end

   assign rsp_new_value   = out_val_ff;
   assign rsp_diff_before = out_diff_ff;

endmodule

@@ hw/rtl/rate_limited_approach_step.sv @@
// rate_limited_approach_step: top level, joins sequencer and datapath
// depends on rlas_pkg, rlas_req_if, rlas_rsp_if, rlas_ctrl, rlas_dpath

// slew rate limiter on a signed 16-bit value. each request word either loads
// its target as the current value or moves the current value toward the
// target by the difference divided by the divisor register, clamped to the
// time scaled maximum step and raised to the time scaled minimum step (with
// a snap to the target on overshoot). every request word returns one result
// word with the new value and the difference seen before the step. one word
// is in work at a time. after acceptance it passes the limit multipliers,
// the restoring divider (one quotient bit per cycle), an update step and
// the load into the output register before its result is offered; the
// next word is taken in the idle state. a single waiting result does not
// block the next request; a second finished word waits in the sequencer
// until the output register is free. the user must write registers only
// while idle; the block itself does not enforce it.

module rate_limited_approach_step (
   input  logic                   clock,
   input  logic                   reset,
   rlas_req_if.sink               req_chan,
   rlas_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  rlas_pkg::csr_idx_type  csr_index,
   input  rlas_pkg::csr_data_type csr_wdata
);

   // command bundle from sequencer to datapath
   rlas_pkg::ctrl_type ctrl;

   // sequencer: handshakes, divider step count, output valid
   rlas_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .ctrl      (ctrl)
   );

   // datapath: registers, current value, divider, step rule, result word
   rlas_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_cmd         (req_chan.cmd),
      .req_target      (req_chan.target),
      .rsp_new_value   (rsp_chan.new_value),
      .rsp_diff_before (rsp_chan.diff_before)
   );

endmodule
